// ===== hdl/amfec_pkg.sv =====
// ----------------------------------------------------------------------------
// amfec_pkg
// Shared constants and helper functions for the voice frame fec encoder:
// golay(23,12) generator rows, scrambler lcg constants and jump-ahead maths.
// ----------------------------------------------------------------------------
package amfec_pkg;

  // field widths
  localparam int unsigned PayloadW = 49;
  localparam int unsigned DataW    = 12;
  localparam int unsigned ParW     = 11;
  localparam int unsigned GolayW   = DataW + ParW;
  localparam int unsigned ExtW     = GolayW + 1;
  localparam int unsigned PlainW   = 25;
  localparam int unsigned LcgW     = 16;
  localparam int unsigned MaskW    = GolayW;

  // scrambler lcg: x <- LcgMul * x + LcgAdd (mod 2^LcgW), seed = 16 * c0
  localparam logic [LcgW-1:0] LcgMul  = 16'd173;
  localparam logic [LcgW-1:0] LcgAdd  = 16'd13849;
  localparam int unsigned     SeedShift = 4;

  // golay(23,12) generator rows, row 0 belongs to the data msb
  localparam logic [ParW-1:0] GolayRows [DataW] = '{
    11'h63a, 11'h31d, 11'h7b4, 11'h3da, 11'h1ed, 11'h6cc,
    11'h366, 11'h1b3, 11'h6e3, 11'h54b, 11'h49f, 11'h475
  };

  // stage enables handed to the scrambler
  typedef struct packed {
    logic s1;
    logic s2;
  } amfec_adv_t;

  // golay check bits of a 12-bit data word
  function automatic logic [ParW-1:0] golay_check(logic [DataW-1:0] data);
    logic [ParW-1:0] par;
    par = '0;
    for (int k = 0; k < DataW; k++) begin
      if (data[DataW-1-k]) par = par ^ GolayRows[k];
    end
    return par;
  endfunction

  // multiplier of the lcg after a number of steps: LcgMul^steps
  function automatic logic [LcgW-1:0] lcg_jump_mul(int unsigned steps);
    logic [2*LcgW-1:0] acc;
    acc = {{LcgW{1'b0}}, {{(LcgW-1){1'b0}}, 1'b1}};
    for (int unsigned i = 0; i < steps; i++) begin
      acc = {{LcgW{1'b0}}, acc[LcgW-1:0]} * {{LcgW{1'b0}}, LcgMul};
    end
    return acc[LcgW-1:0];
  endfunction

  // offset of the lcg after a number of steps, starting from zero
  function automatic logic [LcgW-1:0] lcg_jump_add(int unsigned steps);
    logic [2*LcgW-1:0] acc;
    acc = '0;
    for (int unsigned i = 0; i < steps; i++) begin
      acc = {{LcgW{1'b0}}, acc[LcgW-1:0]} * {{LcgW{1'b0}}, LcgMul}
            + {{LcgW{1'b0}}, LcgAdd};
    end
    return acc[LcgW-1:0];
  endfunction

endpackage

// ===== hdl/amfec_scrambler.sv =====
// ----------------------------------------------------------------------------
// amfec_scrambler
// Two-stage scramble mask generator. Each lcg step is jumped to directly
// from the seed, so all mask bits are computed in parallel lanes.
// ----------------------------------------------------------------------------
module amfec_scrambler (
  input  logic                                clk_i,
  input  amfec_pkg::amfec_adv_t               adv_i,
  input  logic [amfec_pkg::DataW-1:0]         seed_i,
  output logic [amfec_pkg::MaskW-1:0]         mask_o
);

  logic [amfec_pkg::LcgW-1:0] seed;
  logic [amfec_pkg::LcgW-1:0] prod_d [amfec_pkg::MaskW];
  logic [amfec_pkg::LcgW-1:0] prod_q [amfec_pkg::MaskW];
  logic [amfec_pkg::MaskW-1:0] mask_d;
  logic [amfec_pkg::MaskW-1:0] mask_q;

  // seed is sixteen times the first data word, mod 2^16
  assign seed = {seed_i, {amfec_pkg::SeedShift{1'b0}}};

  // one lane per lcg step, lane j gives the state after j+1 steps
  for (genvar j = 0; j < amfec_pkg::MaskW; j++) begin : g_lane
    localparam logic [amfec_pkg::LcgW-1:0] MulK =
      amfec_pkg::lcg_jump_mul(j + 1);
    localparam logic [amfec_pkg::LcgW-1:0] AddK =
      amfec_pkg::lcg_jump_add(j + 1);
    logic [amfec_pkg::LcgW-1:0] state;

    // stage one: product of seed and jump multiplier
    assign prod_d[j] = amfec_pkg::LcgW'(seed * MulK);

    // stage two: add jump offset, top bit is the mask bit (first step at msb)
    assign state = amfec_pkg::LcgW'(prod_q[j] + AddK);
    assign mask_d[amfec_pkg::MaskW-1-j] = state[amfec_pkg::LcgW-1];
  end

  // lane product registers
  always_ff @(posedge clk_i) begin
    if (adv_i.s1) prod_q <= prod_d;
  end

  // mask register
  always_ff @(posedge clk_i) begin
    if (adv_i.s2) mask_q <= mask_d;
  end

  assign mask_o = mask_q;

endmodule

// ===== hdl/ambe_payload_fec_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// ambe_payload_fec_frame_encoder
// Encodes a 49-bit voice payload into a 72-bit protected frame: extended
// golay first word, scrambled golay second word and the unprotected tail.
// ----------------------------------------------------------------------------
// an accepted item passes the stage one, stage two and stage three registers to the output
// throughput: one item per cycle while stall_i is low, set by the three-stage register pipeline
// a stalled output holds only the stages behind it that are full
// reset clears the stage valid bits only; the pipeline is empty after reset
// ----------------------------------------------------------------------------
module ambe_payload_fec_frame_encoder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               stall_o,
  input  logic [amfec_pkg::PayloadW-1:0]     payload_bits_i,
  output logic                               valid_o,
  input  logic                               stall_i,
  output logic [amfec_pkg::ExtW-1:0]         first_codeword_o,
  output logic [amfec_pkg::GolayW-1:0]       second_codeword_o,
  output logic [amfec_pkg::PlainW-1:0]       plain_bits_o
);

  localparam int unsigned C0Lsb = amfec_pkg::PlainW + amfec_pkg::DataW;
  localparam int unsigned C1Lsb = amfec_pkg::PlainW;

  logic ready1, ready2, ready3;
  logic v1_q, v2_q, v3_q;

  logic [amfec_pkg::DataW-1:0]   c0;
  logic [amfec_pkg::DataW-1:0]   c1;

  logic [amfec_pkg::GolayW-1:0]  w0_1_d, w0_1_q;
  logic [amfec_pkg::GolayW-1:0]  w1_1_d, w1_1_q;
  logic [amfec_pkg::PlainW-1:0]  plain_1_q;

  logic [amfec_pkg::ExtW-1:0]    first_2_d, first_2_q;
  logic [amfec_pkg::GolayW-1:0]  w1_2_q;
  logic [amfec_pkg::PlainW-1:0]  plain_2_q;

  logic [amfec_pkg::ExtW-1:0]    first_3_q;
  logic [amfec_pkg::GolayW-1:0]  second_3_d, second_3_q;
  logic [amfec_pkg::PlainW-1:0]  plain_3_q;

  logic [amfec_pkg::MaskW-1:0]   mask;
  amfec_pkg::amfec_adv_t         adv;

  // per-stage ready, a stage moves when it is empty or the next one moves
  assign ready3  = !v3_q || !stall_i;
  assign ready2  = !v2_q || ready3;
  assign ready1  = !v1_q || ready2;
  assign stall_o = !ready1;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready1) v1_q <= valid_i;
      if (ready2) v2_q <= v1_q;
      if (ready3) v3_q <= v2_q;
    end
  end

  // stage one: split payload, golay check bits of both data words
  assign c0     = payload_bits_i[C0Lsb +: amfec_pkg::DataW];
  assign c1     = payload_bits_i[C1Lsb +: amfec_pkg::DataW];
  assign w0_1_d = {c0, amfec_pkg::golay_check(c0)};
  assign w1_1_d = {c1, amfec_pkg::golay_check(c1)};

  always_ff @(posedge clk_i) begin
    if (ready1) begin
      w0_1_q    <= w0_1_d;
      w1_1_q    <= w1_1_d;
      plain_1_q <= payload_bits_i[amfec_pkg::PlainW-1:0];
    end
  end

  // scramble mask, seeded from the first data word, ready alongside stage two
  assign adv.s1 = ready1;
  assign adv.s2 = ready2;

  amfec_scrambler u_scrambler (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .seed_i (c0),
    .mask_o (mask)
  );

  // stage two: even parity extension of the first word
  assign first_2_d = {w0_1_q, ^w0_1_q};

  always_ff @(posedge clk_i) begin
    if (ready2) begin
      first_2_q <= first_2_d;
      w1_2_q    <= w1_1_q;
      plain_2_q <= plain_1_q;
    end
  end

  // stage three: scramble the second word into the output register
  assign second_3_d = w1_2_q ^ mask;

  always_ff @(posedge clk_i) begin
    if (ready3) begin
      first_3_q  <= first_2_q;
      second_3_q <= second_3_d;
      plain_3_q  <= plain_2_q;
    end
  end

  assign valid_o           = v3_q;
  assign first_codeword_o  = first_3_q;
  assign second_codeword_o = second_3_q;
  assign plain_bits_o      = plain_3_q;

endmodule
